/* rtl/assert_macros.svh */
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a given clock and active-low reset
`define CBAE_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// concurrent assertion on the block clock and reset
`define CBAE_ASSERT(label, prop, msg) \
    `CBAE_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

/* rtl/cbae_pkg.sv */
// shared types and constants of the context binary arithmetic encoder
`default_nettype none

package cbae_pkg;

    // field and register widths
    localparam int CMD_W      = 2;
    localparam int SYM_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int RANGE_W    = 32;
    localparam int MODEL_W    = 8;
    localparam int CTX_CFG_W  = 5;
    localparam int SYMB_CFG_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // default table index width
    localparam int MAX_CONTEXT_BITS_DEF = 16;

    // register reset values and limits
    localparam logic [CTX_CFG_W-1:0]  CTX_BITS_RESET = 5'd13;
    localparam logic [SYMB_CFG_W-1:0] SYM_BITS_RESET = 4'd8;
    localparam logic [SYMB_CFG_W-1:0] SYM_BITS_MAX   = 4'd9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_BITS  = 2'd1;

    // input commands
    localparam logic [CMD_W-1:0] CMD_ENCODE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_UPD,
        S_NORM,
        S_FLUSH,
        S_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_sym;
        logic clr_start;
        logic clr_step;
        logic mem_rd;
        logic do_mul;
        logic do_upd;
        logic shift_out;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic len_zero;
        logic bits_done;
        logic top_equal;
        logic range_full;
        logic clr_done;
        logic can_shift;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/cbae_ram.sv */
// generic single write port ram with one registered read port
`default_nettype none

module cbae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/cbae_ctrl.sv */
// encoder controller: sequences clearing, bit coding, normalizing and flushing
`default_nettype none

module cbae_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [cbae_pkg::CMD_W-1:0] s_cmd,
    input  wire cbae_pkg::dp_status_t      status,
    output cbae_pkg::ctrl_cmd_t            ctrl
);

    cbae_pkg::state_t state_reg;
    cbae_pkg::state_t state_next;

    // state register, clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbae_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        case (state_reg)
            cbae_pkg::S_CLEAR: begin
                ctrl.clr_step = 1'b1;
                if (status.clr_done) begin
                    state_next = cbae_pkg::S_IDLE;
                end
            end
            cbae_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_cmd)
                        cbae_pkg::CMD_ENCODE: begin
                            if (!status.len_zero) begin
                                ctrl.load_sym = 1'b1;
                                state_next    = cbae_pkg::S_READ;
                            end
                        end
                        cbae_pkg::CMD_FLUSH: begin
                            state_next = cbae_pkg::S_FLUSH;
                        end
                        cbae_pkg::CMD_RESTART: begin
                            ctrl.clr_start = 1'b1;
                            state_next     = cbae_pkg::S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cbae_pkg::S_READ: begin
                ctrl.mem_rd = 1'b1;
                state_next  = cbae_pkg::S_MUL;
            end
            cbae_pkg::S_MUL: begin
                ctrl.do_mul = 1'b1;
                state_next  = cbae_pkg::S_UPD;
            end
            cbae_pkg::S_UPD: begin
                ctrl.do_upd = 1'b1;
                state_next  = cbae_pkg::S_NORM;
            end
            cbae_pkg::S_NORM: begin
                if (status.top_equal) begin
                    ctrl.shift_out = status.can_shift;
                end else if (status.bits_done) begin
                    state_next = cbae_pkg::S_DONE;
                end else begin
                    state_next = cbae_pkg::S_READ;
                end
            end
            cbae_pkg::S_FLUSH: begin
                if (!status.range_full) begin
                    ctrl.shift_out = status.can_shift;
                end else begin
                    state_next = cbae_pkg::S_DONE;
                end
            end
            cbae_pkg::S_DONE: begin
                if (!status.pend_valid) begin
                    state_next = cbae_pkg::S_IDLE;
                end else if (status.out_free) begin
                    ctrl.finish = 1'b1;
                    state_next  = cbae_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cbae_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/cbae_dpath.sv */
// encoder datapath: range, history, model table, config and output beat
`default_nettype none

module cbae_dpath #(
    parameter int MAX_CONTEXT_BITS = cbae_pkg::MAX_CONTEXT_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire cbae_pkg::ctrl_cmd_t              ctrl,
    output cbae_pkg::dp_status_t                  status,
    input  wire logic [cbae_pkg::SYM_W-1:0]       s_symbol,
    input  wire logic                             cfg_wr,
    input  wire logic [cbae_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cbae_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [cbae_pkg::BYTE_W-1:0]      m_out_byte,
    output logic                                  m_last
);

    localparam int HW    = MAX_CONTEXT_BITS;
    localparam int DEPTH = 1 << HW;
    localparam int RW    = cbae_pkg::RANGE_W;
    localparam int BW    = cbae_pkg::BYTE_W;

    // configuration registers
    logic [cbae_pkg::CTX_CFG_W-1:0]  context_bits_reg;
    logic [cbae_pkg::SYMB_CFG_W-1:0] symbol_bits_reg;

    // coder state
    logic [RW-1:0] range_low_reg;
    logic [RW-1:0] range_high_reg;
    logic [HW-1:0] hist_reg;
    logic [HW-1:0] clr_cnt_reg;
    logic [RW-1:0] prod_reg;
    logic [cbae_pkg::SYM_W-1:0]      sym_reg;
    logic [cbae_pkg::SYMB_CFG_W-1:0] nbits_reg;

    // pending byte and output beat
    logic          pend_valid_reg;
    logic [BW-1:0] pend_byte_reg;
    logic          m_valid_reg;
    logic [BW-1:0] m_byte_reg;
    logic          m_last_reg;

    // combinational signals
    logic [cbae_pkg::CTX_CFG_W-1:0]  ctx_eff;
    logic [HW-1:0]                   ctx_mask;
    logic [HW-1:0]                   ctx_addr;
    logic [cbae_pkg::SYMB_CFG_W-1:0] nbits_eff;
    logic [cbae_pkg::SYMB_CFG_W-1:0] bit_idx;
    logic                            cur_bit;
    logic [cbae_pkg::MODEL_W-1:0]    model_rd;
    logic [cbae_pkg::MODEL_W-1:0]    model_wr;
    logic [7:0]                      w_lut [256];
    logic [7:0]                      w_sel;
    logic [RW-1:0]                   range_diff;
    logic [RW-1:0]                   split;
    logic [4:0]                      ci_inc;
    logic [4:0]                      cj_inc;
    logic                            halve;
    logic [3:0]                      ci_new;
    logic [3:0]                      cj_new;
    logic                            out_free;
    logic                            push;
    logic                            ram_we;
    logic [HW-1:0]                   ram_waddr;

    // split weight table: floor((i+1)*256/(i+j+2)) indexed by the model byte
    for (genvar gi = 0; gi < 256; gi++) begin : g_wlut
        localparam int WI = gi & 15;
        localparam int WJ = gi >> 4;
        localparam int WV = ((WI + 1) * 256) / (WI + WJ + 2);
        assign w_lut[gi] = 8'(WV);
    end

    // context width clamp and history mask
    assign ctx_eff = (context_bits_reg > cbae_pkg::CTX_CFG_W'(HW)) ?
                     cbae_pkg::CTX_CFG_W'(HW) : context_bits_reg;
    always_comb begin
        for (int k = 0; k < HW; k++) begin
            ctx_mask[k] = (cbae_pkg::CTX_CFG_W'(k) < ctx_eff);
        end
    end
    assign ctx_addr = hist_reg & ctx_mask;

    // symbol length clamp and current bit
    assign nbits_eff = (symbol_bits_reg > cbae_pkg::SYM_BITS_MAX) ?
                       cbae_pkg::SYM_BITS_MAX : symbol_bits_reg;
    assign bit_idx   = nbits_reg - 4'd1;
    assign cur_bit   = sym_reg[bit_idx];

    // split and count update
    assign w_sel      = w_lut[model_rd];
    assign range_diff = range_high_reg - range_low_reg;
    assign split      = range_low_reg + prod_reg;
    assign ci_inc     = {1'b0, model_rd[3:0]} + {4'd0, cur_bit};
    assign cj_inc     = {1'b0, model_rd[7:4]} + {4'd0, !cur_bit};
    assign halve      = ci_inc[4] | cj_inc[4];
    assign ci_new     = halve ? ci_inc[4:1] : ci_inc[3:0];
    assign cj_new     = halve ? cj_inc[4:1] : cj_inc[3:0];

    // model table port selection
    assign ram_we    = ctrl.clr_step | ctrl.do_upd;
    assign ram_waddr = ctrl.clr_step ? clr_cnt_reg : ctx_addr;
    assign model_wr  = ctrl.clr_step ? '0 : {cj_new, ci_new};

    cbae_ram #(
        .WIDTH (cbae_pkg::MODEL_W),
        .DEPTH (DEPTH)
    ) u_model (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (model_wr),
        .re    (ctrl.mem_rd),
        .raddr (ctx_addr),
        .rdata (model_rd)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            context_bits_reg <= cbae_pkg::CTX_BITS_RESET;
            symbol_bits_reg  <= cbae_pkg::SYM_BITS_RESET;
        end else if (cfg_wr) begin
            if (cfg_index == cbae_pkg::CFG_CONTEXT_BITS) begin
                context_bits_reg <= cfg_data[cbae_pkg::CTX_CFG_W-1:0];
            end
            if (cfg_index == cbae_pkg::CFG_SYMBOL_BITS) begin
                symbol_bits_reg <= cfg_data[cbae_pkg::SYMB_CFG_W-1:0];
            end
        end
    end

    // range bounds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= '0;
            range_high_reg <= '1;
        end else if (ctrl.do_upd) begin
            if (cur_bit) begin
                range_low_reg <= split + 32'd1;
            end else begin
                range_high_reg <= split;
            end
        end else if (ctrl.shift_out) begin
            range_low_reg  <= {range_low_reg[RW-BW-1:0], {BW{1'b0}}};
            range_high_reg <= {range_high_reg[RW-BW-1:0], {BW{1'b1}}};
        end
    end

    // bit history and clearing counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg    <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (ctrl.clr_start) begin
                hist_reg    <= '0;
                clr_cnt_reg <= '0;
            end else if (ctrl.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctrl.do_upd) begin
                hist_reg <= {hist_reg[HW-2:0], cur_bit};
            end
        end
    end

    // symbol, bit counter and product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nbits_reg <= '0;
        end else if (ctrl.load_sym) begin
            nbits_reg <= nbits_eff;
        end else if (ctrl.do_upd) begin
            nbits_reg <= nbits_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_sym) begin
            sym_reg <= s_symbol;
        end
        if (ctrl.do_mul) begin
            prod_reg <= range_diff[RW-1:BW] * w_sel;
        end
    end

    // pending byte: held back until the next byte or the item end sets last
    assign out_free = !m_valid_reg || m_ready;
    assign push     = (ctrl.shift_out && pend_valid_reg) || ctrl.finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (ctrl.shift_out) begin
            pend_valid_reg <= 1'b1;
        end else if (ctrl.finish) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift_out) begin
            pend_byte_reg <= range_low_reg[RW-1:RW-BW];
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_byte_reg <= pend_byte_reg;
            m_last_reg <= ctrl.finish;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

    // status to controller
    assign status.len_zero   = (symbol_bits_reg == '0);
    assign status.bits_done  = (nbits_reg == '0);
    assign status.top_equal  = (range_low_reg[RW-1:RW-BW] == range_high_reg[RW-1:RW-BW]);
    assign status.range_full = (range_low_reg == '0) && (range_high_reg == '1);
    assign status.clr_done   = (clr_cnt_reg == '1);
    assign status.can_shift  = !pend_valid_reg || out_free;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

endmodule

`default_nettype wire

/* rtl/context_binary_arith_encoder_core.sv */
// top level of the context binary arithmetic encoder
// Carry-less binary range coder with an adaptive context model. An encode beat
// codes the low symbol_bits of s_symbol most significant bit first; each bit
// passes through the model read, weight multiply, range and model update and
// normalize check states in turn, because the next bit's table address depends
// on this bit's history, and each emitted byte adds a step in normalize. The
// item then closes in a done state that releases the held-back last byte, and
// the next beat is taken back in idle. A flush beat emits bytes until the range
// is full again and then closes the same way; unused commands and zero-length
// symbols are dropped in idle and produce nothing. Only one byte is held
// back ahead of the output register, so a stalled result channel stretches the
// byte and closing cycles. The last byte an input beat produces carries m_last.
// After reset and after every restart beat the model table is cleared by a pass
// over all 2**MAX_CONTEXT_BITS entries (65536 at the default) during which
// s_ready is low; configuration writes are accepted at all times and should be
// made while idle.
`default_nettype none

module context_binary_arith_encoder_core #(
    parameter int MAX_CONTEXT_BITS = cbae_pkg::MAX_CONTEXT_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [cbae_pkg::CMD_W-1:0]      s_cmd,
    input  wire logic [cbae_pkg::SYM_W-1:0]      s_symbol,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [cbae_pkg::BYTE_W-1:0]     m_out_byte,
    output logic                                 m_last,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cbae_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cbae_pkg::CFG_DATA_W-1:0] cfg_data
);

    cbae_pkg::ctrl_cmd_t  ctrl;
    cbae_pkg::dp_status_t status;

    // configuration port never stalls
    assign cfg_ready = 1'b1;

    cbae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .status  (status),
        .ctrl    (ctrl)
    );

    cbae_dpath #(
        .MAX_CONTEXT_BITS (MAX_CONTEXT_BITS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .status     (status),
        .s_symbol   (s_symbol),
        .cfg_wr     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

/* rtl/cbae_checker.sv */
// port-level checker for the encoder, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module cbae_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic [cbae_pkg::CMD_W-1:0] s_cmd,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [cbae_pkg::BYTE_W-1:0] m_out_byte,
    input wire logic                       m_last
);

    // a stalled result beat holds
    `CBAE_ASSERT(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_out_byte) && $stable(m_last)), "result beat changed while stalled")

    // restart starts the clearing pass
    `CBAE_ASSERT(a_restart_busy, (s_valid && s_ready && s_cmd == cbae_pkg::CMD_RESTART) |=> !s_ready, "restart did not start clearing")

    // flush occupies the block
    `CBAE_ASSERT(a_flush_busy, (s_valid && s_ready && s_cmd == cbae_pkg::CMD_FLUSH) |=> !s_ready, "flush did not occupy the block")

    // unused command is dropped at once
    `CBAE_ASSERT(a_unused_idle, (s_valid && s_ready && s_cmd == cbae_pkg::CMD_UNUSED) |=> s_ready, "unused command stalled the block")

endmodule

bind context_binary_arith_encoder_core cbae_checker u_cbae_checker (.*);

`default_nettype wire
